[rtl/assert_macros.svh]
// Assertion macros shared by the gradient predictor RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define GPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define GPF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/gpf_pkg.sv]
// Package for the gradient predictor filter: widths, register indexes,
// pixel modes and byte-swap helpers. No dependencies.
`timescale 1ns / 1ps

package gpf_pkg;

    localparam int PIX_W         = 32;
    localparam int COMP_W        = 8;
    localparam int SHIFT_W       = 5;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 8;
    localparam int ROW_WIDTH_DEF = 2048;
    localparam logic [COMP_W-1:0] COMP_FULL = 8'hFF;

    typedef logic [1:0] pix_mode_t;
    localparam pix_mode_t MODE_PACKED24 = 2'd0;
    localparam pix_mode_t MODE_WORD16   = 2'd1;
    localparam pix_mode_t MODE_WORD32   = 2'd2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_PIXEL_MODE  = 4'd0;
    localparam cfg_idx_t REG_RED_MAX     = 4'd1;
    localparam cfg_idx_t REG_GREEN_MAX   = 4'd2;
    localparam cfg_idx_t REG_BLUE_MAX    = 4'd3;
    localparam cfg_idx_t REG_RED_SHIFT   = 4'd4;
    localparam cfg_idx_t REG_GREEN_SHIFT = 4'd5;
    localparam cfg_idx_t REG_BLUE_SHIFT  = 4'd6;
    localparam cfg_idx_t REG_SWAP_BYTES  = 4'd7;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [15:0] swap16(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

endpackage

[rtl/gpf_comp.sv]
// One color component: extract, gradient predict, clamp, residual, repack.
// Purely combinational; uses gpf_pkg.
`timescale 1ns / 1ps

module gpf_comp (
    input  logic [gpf_pkg::PIX_W-1:0]   pixel,
    input  logic [gpf_pkg::SHIFT_W-1:0] shift,
    input  logic [gpf_pkg::COMP_W-1:0]  max_val,
    input  logic [gpf_pkg::COMP_W-1:0]  left_val,
    input  logic [gpf_pkg::COMP_W-1:0]  upper_val,
    input  logic [gpf_pkg::COMP_W-1:0]  upper_left_val,
    output logic [gpf_pkg::COMP_W-1:0]  here,
    output logic [gpf_pkg::COMP_W-1:0]  residual,
    output logic [gpf_pkg::PIX_W-1:0]   packed_part
);
    import gpf_pkg::*;

    logic [PIX_W-1:0]  shifted;
    logic signed [9:0] pred;
    logic [COMP_W-1:0] pred_clamp;

    always_comb begin
        shifted = pixel >> shift;
        here    = shifted[COMP_W-1:0] & max_val;
        pred    = $signed({2'b00, left_val}) + $signed({2'b00, upper_val})
                  - $signed({2'b00, upper_left_val});
        if (pred < 0) begin
            pred_clamp = '0;
        end else if (pred > $signed({2'b00, max_val})) begin
            pred_clamp = max_val;
        end else begin
            pred_clamp = pred[COMP_W-1:0];
        end
        residual    = (here - pred_clamp) & max_val;
        packed_part = PIX_W'(residual) << shift;
    end

endmodule

[rtl/gradient_predictor_filter_top.sv]
// Gradient predictor filter top: config registers, line store, pipeline.
// Uses gpf_pkg, gpf_comp and assert_macros.svh.
// m_valid rises once a pixel has passed stage 1 and the result register; one pixel per clock unless m_ready stalls.
// Stage 1 registers the pixel together with the registered line-store read;
// stage 2 is the result register, written through one pass of gpf_comp.
// Reset clears config to defaults, column, left and upper-left state and all
// valids; the line store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module gradient_predictor_filter_top #(
    parameter int MAX_ROW_WIDTH = gpf_pkg::ROW_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gpf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [gpf_pkg::PIX_W-1:0]      s_pixel,
    input  logic                           s_row_start,
    input  logic                           s_first_row,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [gpf_pkg::PIX_W-1:0]      m_residual_word,
    output logic [gpf_pkg::COMP_W-1:0]     m_red_residual,
    output logic [gpf_pkg::COMP_W-1:0]     m_green_residual,
    output logic [gpf_pkg::COMP_W-1:0]     m_blue_residual
);
    import gpf_pkg::*;

    localparam int COL_W = $clog2(MAX_ROW_WIDTH);
    localparam int LINE_W = 3 * COMP_W;

    // configuration
    pix_mode_t          mode_reg;
    logic [COMP_W-1:0]  max_reg   [3];
    logic [SHIFT_W-1:0] shift_reg [3];
    logic               swap_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_PACKED24;
            max_reg[0]   <= COMP_FULL;
            max_reg[1]   <= COMP_FULL;
            max_reg[2]   <= COMP_FULL;
            shift_reg[0] <= SHIFT_W'(16);
            shift_reg[1] <= SHIFT_W'(8);
            shift_reg[2] <= SHIFT_W'(0);
            swap_reg     <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PIXEL_MODE:  mode_reg     <= cfg_data[1:0];
                REG_RED_MAX:     max_reg[0]   <= cfg_data;
                REG_GREEN_MAX:   max_reg[1]   <= cfg_data;
                REG_BLUE_MAX:    max_reg[2]   <= cfg_data;
                REG_RED_SHIFT:   shift_reg[0] <= cfg_data[SHIFT_W-1:0];
                REG_GREEN_SHIFT: shift_reg[1] <= cfg_data[SHIFT_W-1:0];
                REG_BLUE_SHIFT:  shift_reg[2] <= cfg_data[SHIFT_W-1:0];
                REG_SWAP_BYTES:  swap_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake
    logic s1_valid_reg, m_valid_reg;
    logic advance, accept, s1_fire;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign s1_fire = s1_valid_reg && advance;

    // column counter, read address chosen at accept
    logic [COL_W-1:0] col_reg, rd_addr, col_next;

    always_comb begin
        rd_addr = s_row_start ? '0 : col_reg;
        if ({1'b0, rd_addr} + (COL_W+1)'(1) >= (COL_W+1)'(MAX_ROW_WIDTH)) begin
            col_next = '0;
        end else begin
            col_next = rd_addr + COL_W'(1);
        end
    end

    // stage 1
    logic [PIX_W-1:0]  pix_reg;
    logic              rs_reg, fr_reg;
    logic [COL_W-1:0]  wr_addr_reg;
    logic [LINE_W-1:0] line_mem [MAX_ROW_WIDTH];
    logic [LINE_W-1:0] mem_rd_reg, byp_data_reg;
    logic              byp_reg;
    logic [LINE_W-1:0] here_word;
    logic              wr_hit;

    // a write to the column being read this cycle is forwarded
    assign wr_hit = s1_fire && (wr_addr_reg == rd_addr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            col_reg      <= '0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
                col_reg      <= col_next;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg      <= s_pixel;
            rs_reg       <= s_row_start;
            fr_reg       <= s_first_row;
            wr_addr_reg  <= rd_addr;
            mem_rd_reg   <= line_mem[rd_addr];
            byp_reg      <= wr_hit;
            byp_data_reg <= here_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            line_mem[wr_addr_reg] <= here_word;
        end
    end

    // prediction
    logic [LINE_W-1:0] left_reg, ul_reg;
    logic [LINE_W-1:0] upper_eff, left_eff, ul_eff;
    logic [PIX_W-1:0]  pix_sw;
    logic [COMP_W-1:0] mx      [3];
    logic [COMP_W-1:0] here    [3];
    logic [COMP_W-1:0] res     [3];
    logic [PIX_W-1:0]  part    [3];
    logic [PIX_W-1:0]  packed_word, word;

    always_comb begin
        upper_eff = fr_reg ? '0 : (byp_reg ? byp_data_reg : mem_rd_reg);
        left_eff  = rs_reg ? '0 : left_reg;
        ul_eff    = rs_reg ? '0 : ul_reg;
        case (mode_reg)
            MODE_PACKED24: begin
                mx[0]  = COMP_FULL;
                mx[1]  = COMP_FULL;
                mx[2]  = COMP_FULL;
                pix_sw = swap_reg ? swap32(pix_reg) : pix_reg;
            end
            MODE_WORD16: begin
                mx     = max_reg;
                pix_sw = {16'h0000, swap_reg ? swap16(pix_reg[15:0]) : pix_reg[15:0]};
            end
            default: begin
                mx     = max_reg;
                pix_sw = swap_reg ? swap32(pix_reg) : pix_reg;
            end
        endcase
    end

    for (genvar c = 0; c < 3; c++) begin : g_comp
        localparam int POS = 16 - 8 * c;
        gpf_comp u_comp (
            .pixel          (pix_sw),
            .shift          (shift_reg[c]),
            .max_val        (mx[c]),
            .left_val       (left_eff[POS +: COMP_W]),
            .upper_val      (upper_eff[POS +: COMP_W]),
            .upper_left_val (ul_eff[POS +: COMP_W]),
            .here           (here[c]),
            .residual       (res[c]),
            .packed_part    (part[c])
        );
    end

    always_comb begin
        here_word   = {here[0], here[1], here[2]};
        packed_word = part[0] | part[1] | part[2];
        case (mode_reg)
            MODE_PACKED24: word = '0;
            MODE_WORD16:   word = {16'h0000, swap_reg ? swap16(packed_word[15:0])
                                                      : packed_word[15:0]};
            default:       word = swap_reg ? swap32(packed_word) : packed_word;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
            ul_reg   <= '0;
        end else if (s1_fire) begin
            left_reg <= here_word;
            ul_reg   <= upper_eff;
        end
    end

    // result register
    logic [PIX_W-1:0]  word_reg;
    logic [COMP_W-1:0] red_reg, green_reg, blue_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            word_reg  <= word;
            red_reg   <= res[0];
            green_reg <= res[1];
            blue_reg  <= res[2];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_residual_word  = word_reg;
    assign m_red_residual   = red_reg;
    assign m_green_residual = green_reg;
    assign m_blue_residual  = blue_reg;

    logic m_packed24;
    assign m_packed24 = m_valid_reg && (mode_reg == MODE_PACKED24);

    `GPF_ASSERT(a_s1_holds, (s1_valid_reg && !advance) |=> s1_valid_reg, "stage 1 word lost")
    `GPF_ASSERT(a_out_from_s1, $rose(m_valid_reg) |-> $past(s1_valid_reg), "orphan result")
    `GPF_ASSERT(a_col_after_rs, accept && s_row_start |=> col_reg == COL_W'(1), "column restart")
    `GPF_ASSERT(a_packed24_word, m_packed24 |-> m_residual_word == '0, "word in 24-bit mode")
    `GPF_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !s1_valid_reg && !m_valid_reg, "valid in reset")

endmodule

[sim/gpf_residual_checker.sv]
// Scoreboard for the gradient predictor filter: tracks config writes and
// accepted pixels, predicts residuals and compares them with the result channel.
// Depends on gpf_pkg.
`timescale 1ns / 1ps

module gpf_residual_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [gpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gpf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [gpf_pkg::PIX_W-1:0]      s_pixel,
    input  logic                           s_row_start,
    input  logic                           s_first_row,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [gpf_pkg::PIX_W-1:0]      m_residual_word,
    input  logic [gpf_pkg::COMP_W-1:0]     m_red_residual,
    input  logic [gpf_pkg::COMP_W-1:0]     m_green_residual,
    input  logic [gpf_pkg::COMP_W-1:0]     m_blue_residual,
    output int                             mismatch_count,
    output int                             pending_count
);
    import gpf_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0]  word;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } residual_t;

    // shadow of the config registers
    pix_mode_t          cfg_mode;
    logic [COMP_W-1:0]  comp_max   [3];
    logic [SHIFT_W-1:0] comp_shift [3];
    logic               swap_en;

    // shadow of the filter state; components packed r<<16 | g<<8 | b
    logic [23:0] row_above [ROW_WIDTH_DEF];
    logic [23:0] left_px;
    logic [23:0] upleft_px;
    int unsigned col;

    residual_t residual_q [$];
    int errors;

    function automatic logic [PIX_W-1:0] byte_reverse(input logic [PIX_W-1:0] v);
        logic [PIX_W-1:0] r;
        for (int b = 0; b < 4; b++)
            r[8*b +: 8] = v[8*(3-b) +: 8];
        return r;
    endfunction

    function automatic residual_t filter_pixel(input logic [PIX_W-1:0] raw,
                                               input logic rs, input logic fr);
        logic [PIX_W-1:0]  pix;
        logic [PIX_W-1:0]  here;
        logic [PIX_W-1:0]  packed_res;
        logic [23:0]       above;
        logic [23:0]       here_all;
        logic [COMP_W-1:0] lim [3];
        logic [COMP_W-1:0] res [3];
        int                pred;
        int                pos;
        residual_t         r;

        pix = raw;
        if (cfg_mode == MODE_WORD16)
            pix = swap_en ? {16'h0, raw[7:0], raw[15:8]} : {16'h0, raw[15:0]};
        else if (swap_en)
            pix = byte_reverse(raw);

        if (rs) begin
            col = 0;
            left_px = '0;
            upleft_px = '0;
        end
        above = fr ? 24'h0 : row_above[col];

        here_all = '0;
        packed_res = '0;
        for (int c = 0; c < 3; c++) begin
            lim[c] = (cfg_mode == MODE_PACKED24) ? COMP_FULL : comp_max[c];
            pos = 16 - 8 * c;
            here = (pix >> comp_shift[c]) & {24'h0, lim[c]};
            pred = int'(left_px[pos +: 8]) + int'(above[pos +: 8]) - int'(upleft_px[pos +: 8]);
            if (pred < 0)
                pred = 0;
            else if (pred > int'(lim[c]))
                pred = int'(lim[c]);
            res[c] = (here[7:0] - pred[7:0]) & lim[c];
            packed_res |= {24'h0, res[c]} << comp_shift[c];
            here_all[pos +: 8] = here[7:0];
        end

        row_above[col] = here_all;
        left_px = here_all;
        upleft_px = above;
        col = (col + 1) % ROW_WIDTH_DEF;

        if (cfg_mode == MODE_PACKED24)
            r.word = '0;
        else if (cfg_mode == MODE_WORD16)
            r.word = swap_en ? {16'h0, packed_res[7:0], packed_res[15:8]}
                             : {16'h0, packed_res[15:0]};
        else
            r.word = swap_en ? byte_reverse(packed_res) : packed_res;
        r.red = res[0];
        r.green = res[1];
        r.blue = res[2];
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        residual_t got;
        residual_t want;
        if (!aresetn) begin
            cfg_mode = MODE_PACKED24;
            comp_max = '{COMP_FULL, COMP_FULL, COMP_FULL};
            comp_shift = '{5'd16, 5'd8, 5'd0};
            swap_en = 1'b0;
            left_px = '0;
            upleft_px = '0;
            col = 0;
            residual_q.delete();
            errors = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PIXEL_MODE:  cfg_mode = cfg_data[1:0];
                    REG_RED_MAX:     comp_max[0] = cfg_data;
                    REG_GREEN_MAX:   comp_max[1] = cfg_data;
                    REG_BLUE_MAX:    comp_max[2] = cfg_data;
                    REG_RED_SHIFT:   comp_shift[0] = cfg_data[SHIFT_W-1:0];
                    REG_GREEN_SHIFT: comp_shift[1] = cfg_data[SHIFT_W-1:0];
                    REG_BLUE_SHIFT:  comp_shift[2] = cfg_data[SHIFT_W-1:0];
                    REG_SWAP_BYTES:  swap_en = cfg_data[0];
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                got = '{m_residual_word, m_red_residual, m_green_residual, m_blue_residual};
                if (residual_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result word %h r=%h g=%h b=%h", $realtime,
                                 got.word, got.red, got.green, got.blue);
                end else begin
                    want = residual_q.pop_front();
                    if (got.word !== want.word || got.red !== want.red ||
                        got.green !== want.green || got.blue !== want.blue) begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: residual mismatch exp word=%h r=%h g=%h b=%h",
                                      " got word=%h r=%h g=%h b=%h"}, $realtime,
                                     want.word, want.red, want.green, want.blue,
                                     got.word, got.red, got.green, got.blue);
                    end
                end
            end

            if (s_valid && s_ready)
                residual_q.push_back(filter_pixel(s_pixel, s_row_start, s_first_row));
        end
        mismatch_count <= errors;
        pending_count <= residual_q.size();
    end

endmodule

[sim/tb_gradient_predictor_filter_top.sv]
// Testbench top for gradient_predictor_filter_top: clock, reset, config writes,
// pixel stimulus and result back-pressure; checking lives in gpf_residual_checker.
// Depends on gpf_pkg, gpf_residual_checker and the RTL.
`timescale 1ns / 1ps

module tb_gradient_predictor_filter_top;
    import gpf_pkg::*;

    localparam pix_mode_t MODE_WORD32_ALT = 2'd3;  // decodes as 32-bit mode
    localparam cfg_idx_t  REG_UNMAPPED    = 4'd15;
    localparam int IDLE_PCT       = 37;
    localparam int STALL_LIMIT    = 5000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int RANDOM_WORDS   = 1500;
    localparam int PHASES         = 16;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  cfg_valid   = 1'b0;
    cfg_idx_t              cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  s_valid     = 1'b0;
    logic [PIX_W-1:0]      s_pixel     = '0;
    logic                  s_row_start = 1'b0;
    logic                  s_first_row = 1'b0;
    logic                  m_ready     = 1'b0;
    logic                  cfg_ready;
    logic                  s_ready;
    logic                  m_valid;
    logic [PIX_W-1:0]      m_residual_word;
    logic [COMP_W-1:0]     m_red_residual;
    logic [COMP_W-1:0]     m_green_residual;
    logic [COMP_W-1:0]     m_blue_residual;

    int mismatch_count;
    int pending_count;

    logic idle_on     = 1'b1;
    logic holdoff_req = 1'b0;
    int   hold_left    = 0;
    bit   holdoff_done = 0;
    int   stall_cycles = 0;
    int   words_sent   = 0;

    // columns of the line store that hold data, and where the next word lands
    bit col_written [ROW_WIDTH_DEF];
    int col_track = 0;

    gradient_predictor_filter_top uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pixel          (s_pixel),
        .s_row_start      (s_row_start),
        .s_first_row      (s_first_row),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_residual_word  (m_residual_word),
        .m_red_residual   (m_red_residual),
        .m_green_residual (m_green_residual),
        .m_blue_residual  (m_blue_residual)
    );

    gpf_residual_checker u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pixel          (s_pixel),
        .s_row_start      (s_row_start),
        .s_first_row      (s_first_row),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_residual_word  (m_residual_word),
        .m_red_residual   (m_red_residual),
        .m_green_residual (m_green_residual),
        .m_blue_residual  (m_blue_residual),
        .mismatch_count   (mismatch_count),
        .pending_count    (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // result side: random back-pressure plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (holdoff_req && !holdoff_done) begin
            holdoff_done = 1;
            hold_left = HOLDOFF_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_gradient_predictor_filter_top: FAIL");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic rs, input logic fr);
        logic fr_eff;
        fr_eff = fr;
        if (rs)
            col_track = 0;
        // never read a store column that was not written yet
        if (!fr_eff && !col_written[col_track])
            fr_eff = 1'b1;
        col_written[col_track] = 1'b1;
        col_track = (col_track + 1) % ROW_WIDTH_DEF;
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= pix;
        s_row_start <= rs;
        s_first_row <= fr_eff;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    // sender pauses until every outstanding result has come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_setting(input pix_mode_t mode, input logic [7:0] rmax,
                                 input logic [7:0] gmax, input logic [7:0] bmax,
                                 input logic [4:0] rsh, input logic [4:0] gsh,
                                 input logic [4:0] bsh, input logic swap, input bit junk);
        logic [CFG_DATA_W-1:0] fill;
        // junk settings also put noise in the unused upper data bits
        fill = junk ? CFG_DATA_W'($urandom) : '0;
        write_reg(REG_PIXEL_MODE, {fill[7:2], mode});
        write_reg(REG_RED_MAX, rmax);
        write_reg(REG_GREEN_MAX, gmax);
        write_reg(REG_BLUE_MAX, bmax);
        write_reg(REG_RED_SHIFT, {fill[7:5], rsh});
        write_reg(REG_GREEN_SHIFT, {fill[7:5], gsh});
        write_reg(REG_BLUE_SHIFT, {fill[7:5], bsh});
        write_reg(REG_SWAP_BYTES, {fill[7:1], swap});
        if (junk)
            write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_frame(input int width, input int rows);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < width; c++)
                send_pixel(pick_pixel(), c == 0, r == 0);
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
            send_pixel($urandom, $urandom_range(7) == 0, 1'($urandom_range(1)));
    endtask

    initial begin
        int phase_goal;
        int words_left;
        int frame_w;
        int frame_h;
        int noise_n;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset config; second row hits both clamp directions
        send_pixel(32'h0000_0000, 1'b1, 1'b1);
        send_pixel(32'hFFFF_FFFF, 1'b0, 1'b1);
        send_pixel(32'h00FF_00FF, 1'b0, 1'b1);
        send_pixel(32'h0080_8080, 1'b0, 1'b1);
        send_pixel(32'h0102_0304, 1'b0, 1'b1);
        send_pixel(32'hAA55_AA55, 1'b0, 1'b1);
        send_pixel(32'h0000_0000, 1'b1, 1'b0);
        send_pixel(32'h0000_0000, 1'b0, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_pixel(32'h007F_7F7F, 1'b0, 1'b0);
        send_pixel(32'h0001_0101, 1'b0, 1'b0);
        send_pixel(32'h55AA_55AA, 1'b0, 1'b0);
        send_pixel(32'h8000_0001, 1'b1, 1'b1);
        send_pixel(32'h1234_5678, 1'b0, 1'b0);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: apply_setting(MODE_PACKED24, 8'd7, 8'd0, 8'd1, 5'd16, 5'd8, 5'd0, 1'b1, 1'b0);
                1: apply_setting(MODE_WORD16, 8'd31, 8'd63, 8'd31, 5'd11, 5'd5, 5'd0, 1'b0, 1'b0);
                2: apply_setting(MODE_WORD16, 8'd31, 8'd63, 8'd31, 5'd11, 5'd5, 5'd0, 1'b1, 1'b0);
                3: apply_setting(MODE_WORD32, 8'd255, 8'd255, 8'd255, 5'd16, 5'd8, 5'd0, 1'b1,
                                 1'b0);
                4: apply_setting(MODE_WORD32_ALT, 8'd255, 8'd127, 8'd3, 5'd24, 5'd8, 5'd30,
                                 1'b0, 1'b0);
                5: apply_setting(MODE_WORD32, 8'd0, 8'd1, 8'd255, 5'd0, 5'd31, 5'd12, 1'b1,
                                 1'b0);
                6: apply_setting(MODE_WORD16, 8'd255, 8'd15, 8'd7, 5'd12, 5'd20, 5'd31, 1'b1,
                                 1'b0);
                7: apply_setting(MODE_PACKED24, 8'd255, 8'd255, 8'd255, 5'd31, 5'd28, 5'd25,
                                 1'b0, 1'b0);
                default: apply_setting(pix_mode_t'($urandom_range(3)), 8'($urandom_range(255)),
                                       8'($urandom_range(255)), 8'($urandom_range(255)),
                                       5'($urandom_range(31)), 5'($urandom_range(31)),
                                       5'($urandom_range(31)), 1'($urandom_range(1)), 1'b1);
            endcase

            // phases 4..6 run without any idling on either side
            if (ph == 4)
                idle_on <= 1'b0;
            else if (ph == 7)
                idle_on <= 1'b1;
            if (ph == 2)
                holdoff_req <= 1'b1;

            phase_goal = words_sent + RANDOM_WORDS / PHASES;
            while (words_sent < phase_goal) begin
                // trim each burst to what is left of the phase; the last frame row may run past it
                words_left = phase_goal - words_sent;
                if ($urandom_range(9) < 8) begin
                    frame_w = ($urandom_range(9) == 0) ? $urandom_range(64, 300)
                                                       : $urandom_range(1, 24);
                    frame_h = $urandom_range(1, 5);
                    if (frame_w > words_left)
                        frame_w = words_left;
                    if (frame_w * frame_h > words_left)
                        frame_h = (words_left + frame_w - 1) / frame_w;
                    send_frame(frame_w, frame_h);
                end else begin
                    noise_n = $urandom_range(4, 30);
                    send_noise((noise_n > words_left) ? words_left : noise_n);
                end
            end
            drain();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("tb_gradient_predictor_filter_top: PASS");
        else
            $display("tb_gradient_predictor_filter_top: FAIL");
        $finish;
    end

endmodule

[gradient_predictor_filter_top.f]
+incdir+rtl
rtl/gpf_pkg.sv
rtl/gpf_comp.sv
rtl/gradient_predictor_filter_top.sv
sim/gpf_residual_checker.sv
sim/tb_gradient_predictor_filter_top.sv
